[sv/point_attractor_particle_step_assert.svh]
// Assertion macros used by the checker file of the particle step block.
`ifndef POINT_ATTRACTOR_PARTICLE_STEP_ASSERT_SVH
`define POINT_ATTRACTOR_PARTICLE_STEP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PAP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("particle step assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PAP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("particle step assertion failed");

// Next-cycle implication that also holds across reset.
`define PAP_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("particle step assertion failed");

`endif

[sv/pap_pkg.sv]
// Shared types and constants of the particle step pipeline.
package pap_pkg;

  // iteration pipeline: square root, strength divide, unit-vector divides
  localparam int NITER      = 48;
  localparam int SQRT_STEPS = 32;
  localparam int MDIV_STEPS = 47;
  localparam int UDIV_FIRST = 32;

  localparam logic [46:0] M_LIMIT = 47'h7FFF_FFFF_FFFF;
  localparam logic [16:0] U_ONE   = 17'h1_0000;
  localparam logic [30:0] D_LIMIT = 31'h7FFF_FFFF;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_TARGET_X   = 3'd0,
    REG_TARGET_Y   = 3'd1,
    REG_TARGET_Z   = 3'd2,
    REG_STRENGTH   = 3'd3,
    REG_SOFTENING  = 3'd4,
    REG_ENABLE     = 3'd5,
    REG_RUN_PAUSED = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [2:0][31:0] target;
    logic [31:0]      strength;
    logic [31:0]      softening;
    logic             enable;
    logic             paused;
  } cfg_t;

  // one particle word as it moves down the pipeline
  typedef struct packed {
    logic             valid;
    logic             pause;
    logic             az;       // acceleration forced to zero
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [15:0]      dt;
    logic [2:0]       dneg;
    logic [2:0][30:0] dm;
    logic [2:0][61:0] sq;
    logic [63:0]      r2;
    logic [63:0]      sx;       // square root remainder
    logic [63:0]      sres;     // square root partial result
    logic [64:0]      den;
    logic [64:0]      dr;       // strength divide remainder
    logic [46:0]      mq;
    logic             ovf;
    logic [2:0][31:0] ur;       // unit divide remainders
    logic [2:0][15:0] uq;
    logic [46:0]      m;
    logic [2:0][16:0] u;
    logic [2:0][40:0] pp_lo;
    logic [2:0][39:0] pp_hi;
    logic [2:0][47:0] a;
    logic [2:0][39:0] ap_lo;
    logic [2:0][39:0] ap_hi;
    logic [2:0][31:0] vd;
    logic [2:0][33:0] pv;
    logic [2:0][47:0] ad;
    logic [2:0][39:0] hp_lo;
    logic [2:0][39:0] hp_hi;
    logic [2:0][46:0] half;
  } item_t;

endpackage

[sv/point_attractor_particle_step.sv]
// Top level of the point attractor particle step pipeline.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------
//  config   | cfg_wr_en             | cfg_index[2:0], cfg_data[31:0]
//  input    | in_valid / in_ready   | pos_x/y/z, vel_x/y/z, time_step
//  output   | out_valid / out_ready | new_pos_x/y/z, new_vel_x/y/z
//
// Accepts one particle per cycle while out_ready does not stall it; each passes through
// five front stages, 48 stages of the square root and divide iterations
// (the 32-bit root followed by 16-bit unit divides sets that length; the
// 47-bit strength divide fits within it), and eight multiply and sum stages.
// Reset is synchronous; it clears the stage valid bits and sets the configuration registers to their defaults.
// When out_ready is low with a word waiting, the whole pipeline holds.
module point_attractor_particle_step
  import pap_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  input  logic [31:0] vel_x,
  input  logic [31:0] vel_y,
  input  logic [31:0] vel_z,
  input  logic [15:0] time_step,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] new_pos_x,
  output logic [31:0] new_pos_y,
  output logic [31:0] new_pos_z,
  output logic [31:0] new_vel_x,
  output logic [31:0] new_vel_y,
  output logic [31:0] new_vel_z
);

  function automatic logic [31:0] sat32(logic [49:0] v);
    if (!v[49] && (v[48:31] != '0)) return 32'h7FFF_FFFF;
    if (v[49] && (v[48:31] != '1)) return 32'h8000_0000;
    return v[31:0];
  endfunction

  cfg_t  cfg;
  logic  adv;
  item_t s0, s1, s2, s3, s4, it_out, p1, p2, p3, p4, p5, p6, p7, p8;
  item_t s0_next, s1_next, s2_next, s3_next, s4_next;
  item_t p1_next, p2_next, p3_next, p4_next, p5_next, p6_next, p7_next, p8_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target    <= '0;
      cfg.strength  <= 32'd65536;
      cfg.softening <= 32'd6554;
      cfg.enable    <= 1'b0;
      cfg.paused    <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TARGET_X:   cfg.target[0] <= cfg_data;
        REG_TARGET_Y:   cfg.target[1] <= cfg_data;
        REG_TARGET_Z:   cfg.target[2] <= cfg_data;
        REG_STRENGTH:   cfg.strength  <= cfg_data;
        REG_SOFTENING:  cfg.softening <= cfg_data;
        REG_ENABLE:     cfg.enable    <= cfg_data[0];
        REG_RUN_PAUSED: cfg.paused    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // hold everything while the output word waits
  assign adv      = !p8.valid || out_ready;
  assign in_ready = adv;

  // capture the input word
  always_comb begin
    s0_next        = '0;
    s0_next.valid  = in_valid;
    s0_next.pause  = cfg.paused;
    s0_next.az     = !cfg.enable;
    s0_next.pos[0] = pos_x;
    s0_next.pos[1] = pos_y;
    s0_next.pos[2] = pos_z;
    s0_next.vel[0] = vel_x;
    s0_next.vel[1] = vel_y;
    s0_next.vel[2] = vel_z;
    s0_next.dt     = time_step;
  end

  // offset to target, magnitude clamped to 31 bits
  always_comb begin
    logic [32:0] d;
    logic [32:0] mag;
    s1_next = s0;
    for (int l = 0; l < 3; l++) begin
      d = {cfg.target[l][31], cfg.target[l]} - {s0.pos[l][31], s0.pos[l]};
      mag = d[32] ? 33'(~d + 33'd1) : d;
      s1_next.dneg[l] = d[32];
      s1_next.dm[l]   = (mag[32:31] != 2'b00) ? D_LIMIT : mag[30:0];
    end
  end

  // squares
  always_comb begin
    s2_next = s1;
    for (int l = 0; l < 3; l++) begin
      s2_next.sq[l] = 62'(s1.dm[l]) * 62'(s1.dm[l]);
    end
  end

  // squared distance
  always_comb begin
    s3_next = s2;
    s3_next.r2 = 64'(s2.sq[0]) + 64'(s2.sq[1]) + 64'(s2.sq[2]);
  end

  // denominator, divide overflow, iteration start values
  always_comb begin
    s4_next      = s3;
    s4_next.den  = 65'(s3.r2) + {17'd0, cfg.softening, 16'd0};
    s4_next.ovf  = {48'd0, cfg.strength[31:15]} >= s4_next.den;
    s4_next.dr   = {48'd0, cfg.strength[31:15]};
    s4_next.mq   = '0;
    s4_next.sx   = s3.r2;
    s4_next.sres = '0;
    s4_next.az   = s3.az || (s3.r2 == '0);
  end

  pap_iter u_iter (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .strength (cfg.strength),
    .din      (s4),
    .dout     (it_out)
  );

  // cap the magnitude and the unit components
  always_comb begin
    p1_next   = it_out;
    p1_next.m = it_out.ovf ? M_LIMIT : it_out.mq;
    for (int l = 0; l < 3; l++) begin
      p1_next.u[l] = ({1'b0, it_out.dm[l]} == it_out.sres[31:0]) ?
                     U_ONE : {1'b0, it_out.uq[l]};
    end
  end

  // magnitude times unit, two partial products
  always_comb begin
    p2_next = p1;
    for (int l = 0; l < 3; l++) begin
      p2_next.pp_lo[l] = 41'(p1.m[23:0]) * 41'(p1.u[l]);
      p2_next.pp_hi[l] = 40'(p1.m[46:24]) * 40'(p1.u[l]);
    end
  end

  // acceleration magnitude
  always_comb begin
    logic [63:0] s;
    p3_next = p2;
    for (int l = 0; l < 3; l++) begin
      s = {p2.pp_hi[l], 24'd0} + 64'(p2.pp_lo[l]);
      p3_next.a[l] = p2.az ? 48'd0 : s[63:16];
    end
  end

  // a*dt partials, v*dt
  always_comb begin
    logic [31:0] vm;
    logic [47:0] vp;
    p4_next = p3;
    for (int l = 0; l < 3; l++) begin
      p4_next.ap_lo[l] = 40'(p3.a[l][23:0]) * 40'(p3.dt);
      p4_next.ap_hi[l] = 40'(p3.a[l][47:24]) * 40'(p3.dt);
      vm = p3.vel[l][31] ? 32'(~p3.vel[l] + 32'd1) : p3.vel[l];
      vp = 48'(vm) * 48'(p3.dt);
      p4_next.vd[l] = vp[47:16];
    end
  end

  // a*dt, position plus v*dt
  always_comb begin
    logic [63:0] s;
    logic [32:0] vds;
    p5_next = p4;
    for (int l = 0; l < 3; l++) begin
      s = {p4.ap_hi[l], 24'd0} + 64'(p4.ap_lo[l]);
      p5_next.ad[l] = s[63:16];
      vds = p4.vel[l][31] ? 33'(-{1'b0, p4.vd[l]}) : {1'b0, p4.vd[l]};
      p5_next.pv[l] = {{2{p4.pos[l][31]}}, p4.pos[l]} + {vds[32], vds};
    end
  end

  // a*dt*dt partials
  always_comb begin
    p6_next = p5;
    for (int l = 0; l < 3; l++) begin
      p6_next.hp_lo[l] = 40'(p5.ad[l][23:0]) * 40'(p5.dt);
      p6_next.hp_hi[l] = 40'(p5.ad[l][47:24]) * 40'(p5.dt);
    end
  end

  // half step term
  always_comb begin
    logic [63:0] s;
    p7_next = p6;
    for (int l = 0; l < 3; l++) begin
      s = {p6.hp_hi[l], 24'd0} + 64'(p6.hp_lo[l]);
      p7_next.half[l] = s[63:17];
    end
  end

  // final sums, saturate; pass through when paused
  always_comb begin
    logic [49:0] hs;
    logic [49:0] as;
    p8_next = p7;
    for (int l = 0; l < 3; l++) begin
      hs = p7.dneg[l] ? 50'(-{3'd0, p7.half[l]}) : {3'd0, p7.half[l]};
      as = p7.dneg[l] ? 50'(-{2'd0, p7.ad[l]}) : {2'd0, p7.ad[l]};
      if (!p7.pause) begin
        p8_next.pos[l] = sat32({{16{p7.pv[l][33]}}, p7.pv[l]} + hs);
        p8_next.vel[l] = sat32({{18{p7.vel[l][31]}}, p7.vel[l]} + as);
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s0.valid <= 1'b0;
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
      s4.valid <= 1'b0;
      p1.valid <= 1'b0;
      p2.valid <= 1'b0;
      p3.valid <= 1'b0;
      p4.valid <= 1'b0;
      p5.valid <= 1'b0;
      p6.valid <= 1'b0;
      p7.valid <= 1'b0;
      p8.valid <= 1'b0;
    end else if (adv) begin
      s0 <= s0_next;
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
      s4 <= s4_next;
      p1 <= p1_next;
      p2 <= p2_next;
      p3 <= p3_next;
      p4 <= p4_next;
      p5 <= p5_next;
      p6 <= p6_next;
      p7 <= p7_next;
      p8 <= p8_next;
    end
  end

  assign out_valid = p8.valid;
  assign new_pos_x = p8.pos[0];
  assign new_pos_y = p8.pos[1];
  assign new_pos_z = p8.pos[2];
  assign new_vel_x = p8.vel[0];
  assign new_vel_y = p8.vel[1];
  assign new_vel_z = p8.vel[2];

endmodule

[sv/pap_iter.sv]
// Iteration pipeline: bitwise square root, strength divide and unit-vector divides.
module pap_iter
  import pap_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic [31:0] strength,
  input  item_t       din,
  output item_t       dout
);

  // one step of each running iteration, chosen by the stage number
  function automatic item_t iter_step(item_t x, int j, logic [31:0] str);
    item_t       y;
    logic [63:0] bitv;
    logic [63:0] t;
    logic        nb;
    logic [65:0] r;
    logic [32:0] rr;
    logic [32:0] rl;
    int          k;
    y = x;
    k = j - UDIV_FIRST;
    // square root, one result bit per stage
    if (j < SQRT_STEPS) begin
      bitv = 64'd1 << (62 - 2 * j);
      t = x.sres + bitv;
      if (x.sx >= t) begin
        y.sx   = x.sx - t;
        y.sres = (x.sres >> 1) + bitv;
      end else begin
        y.sres = x.sres >> 1;
      end
    end
    // strength divide, restoring, one quotient bit per stage
    if (j < MDIV_STEPS) begin
      if (j <= 14) begin
        nb = str[14 - j];
      end else begin
        nb = 1'b0;
      end
      r = {x.dr, nb};
      if (r >= {1'b0, x.den}) begin
        y.dr = 65'(r - {1'b0, x.den});
        y.mq[46 - j] = 1'b1;
      end else begin
        y.dr = r[64:0];
        y.mq[46 - j] = 1'b0;
      end
    end
    // unit-vector divides once the root is known
    if (j >= UDIV_FIRST) begin
      rl = {1'b0, x.sres[31:0]};
      for (int l = 0; l < 3; l++) begin
        if (j == UDIV_FIRST) begin
          rr = {1'b0, x.dm[l], 1'b0};
        end else begin
          rr = {x.ur[l], 1'b0};
        end
        if (rr >= rl) begin
          y.ur[l] = 32'(rr - rl);
          y.uq[l][15 - k] = 1'b1;
        end else begin
          y.ur[l] = rr[31:0];
          y.uq[l][15 - k] = 1'b0;
        end
      end
    end
    return y;
  endfunction

  item_t pipe [NITER+1];

  assign pipe[0] = din;

  // advance every stage together; clear valid on reset
  for (genvar j = 0; j < NITER; j++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[j+1].valid <= 1'b0;
      end else if (adv) begin
        pipe[j+1] <= iter_step(pipe[j], j, strength);
      end
    end
  end

  assign dout = pipe[NITER];

endmodule

[sv/pap_checker.sv]
// Port-level checker for the particle step block, bound to the top level.
`include "point_attractor_particle_step_assert.svh"

module pap_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_wr_en,
  input logic [2:0]  cfg_index,
  input logic [31:0] cfg_data,
  input logic        in_valid,
  input logic        in_ready,
  input logic [31:0] pos_x,
  input logic [31:0] pos_y,
  input logic [31:0] pos_z,
  input logic [31:0] vel_x,
  input logic [31:0] vel_y,
  input logic [31:0] vel_z,
  input logic [15:0] time_step,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] new_pos_x,
  input logic [31:0] new_pos_y,
  input logic [31:0] new_pos_z,
  input logic [31:0] new_vel_x,
  input logic [31:0] new_vel_y,
  input logic [31:0] new_vel_z
);

  // a stalled output word stays
  `PAP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // a stalled output word keeps its payload
  `PAP_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(new_pos_x) && $stable(new_pos_y) && $stable(new_pos_z) && $stable(new_vel_x) && $stable(new_vel_y) && $stable(new_vel_z))

  // input side takes a word exactly when the output does not block
  `PAP_ASSERT_NOW(a_ready_rule, clk, rst, 1'b1, in_ready == (out_ready || !out_valid))

  // reset empties the pipeline
  `PAP_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !out_valid)

endmodule

bind point_attractor_particle_step pap_checker u_pap_checker (.*);
